>>> design/tks_pkg.sv
// Types, codes and defaults shared by the sorted top-k table.
// No dependencies; the compare unit, the top level and the bench files import it.
`timescale 1ns / 1ps

package tks_pkg;

	localparam int TKS_DEPTH = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef struct packed {
		logic               command;
		logic [3:0]         read_index;
		logic [31:0]        score;
		logic [15:0]        quest;
		logic [31:0]        name_ref;
		logic [1:0]         reason;
		logic [15:0]        level;
		logic signed [15:0] monster;
		logic [2:0]         char_class;
		logic [31:0]        system_ref;
		logic [31:0]        login_ref;
	} cmd_t;

	typedef struct packed {
		logic               inserted;
		logic [3:0]         rank;
		logic [31:0]        out_score;
		logic [15:0]        out_quest;
		logic [31:0]        out_name_ref;
		logic [1:0]         out_reason;
		logic [15:0]        out_level;
		logic signed [15:0] out_monster;
		logic [2:0]         out_class;
		logic [31:0]        out_system_ref;
		logic [31:0]        out_login_ref;
	} rsp_t;

	// one stored table slot
	typedef struct packed {
		logic [31:0]        score;
		logic [15:0]        quest;
		logic [31:0]        name;
		logic [1:0]         reason;
		logic [15:0]        level;
		logic signed [15:0] monster;
		logic [2:0]         cls;
		logic [31:0]        sys;
		logic [31:0]        login;
	} entry_t;

	// compare unit verdict on one slot
	typedef struct packed {
		logic ge;
		logic same_owner;
		logic empty;
	} cmp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_FETCH_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_PLACE,
		ST_RESP
	} state_t;

endpackage

>>> design/tks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/tks_cmp.sv
// Shared compare unit: score order, owner match and empty check of one slot against the key.
// Depends on tks_pkg.
`timescale 1ns / 1ps

module tks_cmp (
	input  tks_pkg::entry_t slot,
	input  logic [31:0]     score,
	input  logic [31:0]     login_ref,
	input  logic [31:0]     system_ref,
	input  logic [2:0]      char_class,
	output tks_pkg::cmp_t   res
);

	import tks_pkg::*;

	always_comb begin
		res.ge         = (score >= slot.score);
		res.same_owner = (slot.login == login_ref) && (slot.sys == system_ref) &&
		                 (slot.cls == char_class);
		res.empty      = (slot.score == 32'd0);
	end

endmodule

>>> design/top_k_sorted_insert.sv
// Top level of the sorted top-k table: sequencer, slot RAM and compare unit.
// Depends on tks_pkg, tks_ram and tks_cmp.
`timescale 1ns / 1ps

// The table holds DEPTH entries in descending score order in one RAM with a
// single write and a single registered read port. An insert walks the slots
// from the top through one shared compare unit, a read state then a check
// state per slot, until it finds its place (and, with one_per_owner set, a
// same-owner entry to drop), then moves the displaced slots down one at a
// time, a read state then a write state per slot, and writes the new entry.
// A read fetches its slot through the read port; an index beyond the table
// answers zero without a fetch. A finished result waits in the response
// state until the output register is free. A per-slot valid bit, cleared by
// reset, makes the table read as all zero at once, so there is no clearing
// pass. The finished result sits in an output register, and the next command
// beat is taken while it waits.
// Write the configuration only while the block is idle.
module top_k_sorted_insert #(
	parameter int DEPTH = tks_pkg::TKS_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tks_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tks_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	import tks_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	state_t state_q, state_d;

	cmd_t          cmd_q;
	logic          opo_q;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] pos_q, pos_d;
	logic          found_q, found_d;
	logic [DEPTH-1:0] valid_q;
	logic          rvalid_q;
	rsp_t          res_q, res_d;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic          cmd_ld, rsp_ld;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata, rd_entry, new_entry;
	cmp_t          cmp;

	// scan helpers
	logic          hit, done_del, reject;
	logic [AW-1:0] p_here, d_here;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a slot that was never written reads as all zero
	assign rd_entry = rvalid_q ? ram_rdata : '0;

	always_comb begin
		new_entry.score   = cmd_q.score;
		new_entry.quest   = cmd_q.quest;
		new_entry.name    = cmd_q.name_ref;
		new_entry.reason  = cmd_q.reason;
		new_entry.level   = cmd_q.level;
		new_entry.monster = cmd_q.monster;
		new_entry.cls     = cmd_q.char_class;
		new_entry.sys     = cmd_q.system_ref;
		new_entry.login   = cmd_q.login_ref;
	end

	tks_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tks_cmp u_cmp (
		.slot       (rd_entry),
		.score      (cmd_q.score),
		.login_ref  (cmd_q.login_ref),
		.system_ref (cmd_q.system_ref),
		.char_class (cmd_q.char_class),
		.res        (cmp)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM control and register updates
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		found_d   = found_q;
		res_d     = res_q;
		cmd_ld    = 1'b0;
		rsp_ld    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rd_entry;
		ram_raddr = idx_q;

		// insert point is this slot unless an earlier one already took it
		hit      = found_q || cmp.ge;
		p_here   = found_q ? pos_q : idx_q;
		// with owner mode off stop at once, else at an empty slot, a same-owner slot to drop, or the bottom
		done_del = !opo_q || cmp.empty || cmp.same_owner || (idx_q == LAST);
		d_here   = (opo_q && !cmp.empty && cmp.same_owner) ? idx_q : LAST;
		reject   = !found_q && !cmp.ge && ((opo_q && cmp.same_owner) || (idx_q == LAST));

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_ld  = 1'b1;
					found_d = 1'b0;
					if (cmd.command == CMD_READ) begin
						if ({28'd0, cmd.read_index} < 32'(DEPTH)) begin
							idx_d   = AW'(cmd.read_index);
							state_d = ST_FETCH;
						end else begin
							res_d   = '0;
							state_d = ST_RESP;
						end
					end else begin
						idx_d   = '0;
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_FETCH_CHK;
			end
			ST_FETCH_CHK: begin
				res_d                = '0;
				res_d.out_score      = rd_entry.score;
				res_d.out_quest      = rd_entry.quest;
				res_d.out_name_ref   = rd_entry.name;
				res_d.out_reason     = rd_entry.reason;
				res_d.out_level      = rd_entry.level;
				res_d.out_monster    = rd_entry.monster;
				res_d.out_class      = rd_entry.cls;
				res_d.out_system_ref = rd_entry.sys;
				res_d.out_login_ref  = rd_entry.login;
				state_d              = ST_RESP;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (reject) begin
					res_d   = '0;
					state_d = ST_RESP;
				end else if (hit && done_del) begin
					pos_d   = p_here;
					found_d = 1'b1;
					idx_d   = d_here;
					state_d = (d_here == p_here) ? ST_PLACE : ST_MOVE_RD;
				end else begin
					pos_d   = p_here;
					found_d = hit;
					idx_d   = idx_q + AW'(1);
					state_d = ST_SCAN_RD;
				end
			end
			ST_MOVE_RD: begin
				ram_raddr = idx_q - AW'(1);
				state_d   = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = rd_entry;
				idx_d     = idx_q - AW'(1);
				state_d   = ((idx_q - AW'(1)) == pos_q) ? ST_PLACE : ST_MOVE_RD;
			end
			ST_PLACE: begin
				ram_we         = 1'b1;
				ram_waddr      = pos_q;
				ram_wdata      = new_entry;
				res_d          = '0;
				res_d.inserted = 1'b1;
				res_d.rank     = 4'(pos_q);
				state_d        = ST_RESP;
			end
			ST_RESP: begin
				// hold until the output register is free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opo_q       <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			rvalid_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				opo_q <= cfg_data;
			end
			idx_q    <= idx_d;
			pos_q    <= pos_d;
			found_q  <= found_d;
			rvalid_q <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_ld) begin
			cmd_q <= cmd;
		end
		res_q <= res_d;
		if (rsp_ld) begin
			rsp_q <= res_q;
		end
	end

	// A result beat starts only from the response state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("response launched outside the response state");

	// Moves always stay strictly below the insert point.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE_RD || state_q == ST_MOVE_WR) |-> (idx_q > pos_q))
		else $error("slot move at or above the insert point");

	// An accepted command beat starts work on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q != ST_IDLE))
		else $error("accepted command left the sequencer idle");

	// A rejected insert reports rank zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.inserted) |-> (rsp_q.rank == 4'd0))
		else $error("rejected insert carries a rank");

endmodule

>>> bench/tks_table_checker.sv
// Scoreboard for the sorted top-k table: watches the command, response and
// configuration channels, mirrors the table and checks every response beat.
// Depends on tks_pkg.
`timescale 1ns / 1ps

module tks_table_checker #(
	parameter int DEPTH = tks_pkg::TKS_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_ready,
	input  tks_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  tks_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic          cfg_data,
	output int            errors,
	output int            pending
);
	import tks_pkg::*;

	entry_t board [DEPTH];
	logic   unique_owner;
	rsp_t   expected_rsp [$];
	int     reported;

	function automatic bit owner_match(int slot, cmd_t c);
		return board[slot].login == c.login_ref && board[slot].sys == c.system_ref &&
			board[slot].cls == c.char_class;
	endfunction

	// Update the mirrored table for one command beat and return its response.
	function automatic rsp_t apply_command(cmd_t c);
		rsp_t r;
		int   pos;
		int   k;
		int   m;
		r = '0;
		if (c.command == CMD_READ) begin
			if (c.read_index < DEPTH) begin
				r.out_score      = board[c.read_index].score;
				r.out_quest      = board[c.read_index].quest;
				r.out_name_ref   = board[c.read_index].name;
				r.out_reason     = board[c.read_index].reason;
				r.out_level      = board[c.read_index].level;
				r.out_monster    = board[c.read_index].monster;
				r.out_class      = board[c.read_index].cls;
				r.out_system_ref = board[c.read_index].sys;
				r.out_login_ref  = board[c.read_index].login;
			end
			return r;
		end
		// ties go ahead; a better entry of the same owner blocks the insert
		for (pos = 0; pos < DEPTH; pos++) begin
			if (c.score >= board[pos].score)
				break;
			if (unique_owner && owner_match(pos, c))
				return r;
		end
		if (pos == DEPTH)
			return r;
		// drop the first lower entry of the same owner, stopping at an empty slot
		if (unique_owner) begin
			for (k = pos; k < DEPTH; k++) begin
				if (board[k].score == '0)
					break;
				if (owner_match(k, c)) begin
					for (m = k; m < DEPTH - 1; m++)
						board[m] = board[m + 1];
					board[DEPTH - 1].score = '0;
					break;
				end
			end
		end
		for (k = DEPTH - 1; k > pos; k--)
			board[k] = board[k - 1];
		board[pos] = '{c.score, c.quest, c.name_ref, c.reason, c.level, c.monster,
			c.char_class, c.system_ref, c.login_ref};
		r.inserted = 1'b1;
		r.rank = 4'(pos);
		return r;
	endfunction

	function automatic bit field_differs(string name, logic [31:0] exp, logic [31:0] act);
		if (exp === act)
			return 1'b0;
		if (reported < 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
		reported++;
		return 1'b1;
	endfunction

	task automatic compare_rsp(rsp_t exp, rsp_t act);
		bit bad;
		bad = 1'b0;
		bad |= field_differs("inserted", 32'(exp.inserted), 32'(act.inserted));
		bad |= field_differs("rank", 32'(exp.rank), 32'(act.rank));
		bad |= field_differs("out_score", exp.out_score, act.out_score);
		bad |= field_differs("out_quest", 32'(exp.out_quest), 32'(act.out_quest));
		bad |= field_differs("out_name_ref", exp.out_name_ref, act.out_name_ref);
		bad |= field_differs("out_reason", 32'(exp.out_reason), 32'(act.out_reason));
		bad |= field_differs("out_level", 32'(exp.out_level), 32'(act.out_level));
		bad |= field_differs("out_monster", 32'(exp.out_monster), 32'(act.out_monster));
		bad |= field_differs("out_class", 32'(exp.out_class), 32'(act.out_class));
		bad |= field_differs("out_system_ref", exp.out_system_ref, act.out_system_ref);
		bad |= field_differs("out_login_ref", exp.out_login_ref, act.out_login_ref);
		if (bad)
			errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (board[i])
				board[i] = '0;
			unique_owner = 1'b0;
			expected_rsp.delete();
			errors = 0;
			reported = 0;
		end else begin
			// retire before predicting: a response never belongs to this edge's command
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					if (reported < 10)
						$display("%0t: response beat with nothing expected", $time);
					reported++;
					errors++;
				end else begin
					compare_rsp(expected_rsp.pop_front(), rsp);
				end
			end
			if (cfg_valid && cfg_ready)
				unique_owner = cfg_data;
			if (cmd_valid && cmd_ready)
				expected_rsp.push_back(apply_command(cmd));
		end
		pending <= expected_rsp.size();
	end

endmodule

>>> bench/top_k_sorted_insert_test.sv
// Testbench top for the sorted top-k table: clock, reset, command and
// configuration stimulus, receiver back-pressure and the verdict.
// Depends on tks_pkg, top_k_sorted_insert and tks_table_checker.
`timescale 1ns / 1ps

module top_k_sorted_insert_test;
	import tks_pkg::*;

	localparam int DEPTH           = TKS_DEPTH;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 244;
	// Ample for the worst insert, also with long sender gaps and receiver stalls.
	localparam int CYCLE_LIMIT     = 2_000_000;
	// Settle time after the last response: catches stray response beats.
	localparam int DRAIN_CYCLES    = 4 * DEPTH + 8;
	// Owner codes reused often so that same-owner matches are common.
	localparam logic [31:0] LOGIN_A = 32'h1234_5678;
	localparam logic [31:0] SYS_A   = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	int errors;
	int pending;
	int gap_pct;
	int stall_pct;
	int cycle_count;
	int unsigned item_index;
	logic [31:0] recent_scores [4];

	top_k_sorted_insert #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	tks_table_checker #(
		.DEPTH(DEPTH)
	) board_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: decide readiness for the next edge at every falling edge.
	always @(negedge clk) begin
		rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Hard stop: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Insert beat with a random payload around the given sort key and owner.
	function automatic cmd_t insert_cmd(logic [31:0] score, logic [31:0] login,
			logic [31:0] sys, logic [2:0] cls);
		cmd_t c;
		c.command    = CMD_INSERT;
		c.read_index = 4'($urandom);
		c.score      = score;
		c.quest      = 16'($urandom);
		c.name_ref   = $urandom;
		c.reason     = 2'($urandom);
		c.level      = 16'($urandom);
		c.monster    = 16'($urandom);
		c.char_class = cls;
		c.system_ref = sys;
		c.login_ref  = login;
		return c;
	endfunction

	function automatic cmd_t read_cmd(logic [3:0] slot);
		cmd_t c;
		c = insert_cmd($urandom, $urandom, $urandom, 3'($urandom));
		c.command = CMD_READ;
		c.read_index = slot;
		return c;
	endfunction

	// Random beat. Keys mostly come from a window that climbs with the item
	// count, so old entries age out and inserts land at every rank; the rest
	// are zero, full-range, or repeats of recent keys to force ties.
	function automatic cmd_t random_cmd();
		cmd_t        c;
		logic [31:0] score;
		logic [31:0] login;
		logic [31:0] sys;
		logic [2:0]  cls;
		int unsigned pick;
		logic [63:0] base;
		base = 64'(item_index) * 64'd2_000_000;
		pick = $urandom_range(99);
		if (pick < 3)
			score = '0;
		else if (pick < 6)
			score = $urandom;
		else if (pick < 21)
			score = recent_scores[$urandom_range(3)];
		else
			score = 32'(base + 64'($urandom_range(32_000_000)));
		case ($urandom_range(4))
			0: login = 32'h0000_0001;
			1: login = 32'hFFFF_FFFE;
			2: login = 32'h8000_0000;
			3: login = LOGIN_A;
			default: login = $urandom;
		endcase
		if ($urandom_range(99) < 85)
			sys = $urandom_range(1) ? SYS_A : 32'h0;
		else
			sys = $urandom;
		if ($urandom_range(9) < 7)
			cls = $urandom_range(1) ? 3'd1 : 3'd6;
		else
			cls = 3'($urandom);
		c = insert_cmd(score, login, sys, cls);
		if ($urandom_range(99) < 25)
			c.command = CMD_READ;
		return c;
	endfunction

	// Offer one command beat and hold it until accepted. Enter and leave at a
	// falling edge; valid stays high on exit so back-to-back beats need no
	// second assignment in the same step.
	task automatic push_cmd(input cmd_t c);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait for every predicted response to come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write the owner mode only once the table has gone quiet.
	task automatic write_owner_mode(input logic mode);
		wait_drained();
		cfg_data <= mode;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		int   i;
		int   p;
		int   n;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		item_index = 0;
		foreach (recent_scores[k])
			recent_scores[k] = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, one entry per owner off: empty reads, zero key, full
		// fields, a tie at the top, a full table, a drop-off and a key too
		// low to place.
		write_owner_mode(1'b0);
		push_cmd(read_cmd(4'd0));
		push_cmd(read_cmd(4'd15));
		c = '0;
		push_cmd(c);
		c = '1;
		c.command = CMD_INSERT;
		c.monster = 16'sh7FFF;
		push_cmd(c);
		c.monster = 16'sh8000;
		c.char_class = 3'd0;
		push_cmd(c);
		for (i = 0; i < 12; i++)
			push_cmd(insert_cmd(32'd1000 + 32'(i), LOGIN_A, SYS_A, 3'd3));
		push_cmd(insert_cmd(32'd100, LOGIN_A, SYS_A, 3'd3));
		push_cmd(insert_cmd(32'd50, 32'h0, 32'h0, 3'd0));
		push_cmd(insert_cmd(32'd10, 32'h0, 32'h0, 3'd0));
		push_cmd(read_cmd(4'd15));

		// Owner mode on: a same-owner entry above blocks, one below is
		// removed and the table closes up behind it.
		write_owner_mode(1'b1);
		push_cmd(insert_cmd(32'd1005, LOGIN_A, SYS_A, 3'd3));
		push_cmd(insert_cmd(32'd5000, LOGIN_A, SYS_A, 3'd3));
		push_cmd(read_cmd(4'd15));
		push_cmd(read_cmd(4'd2));

		// Random phases: each idling style once with the owner mode off and
		// once with it on.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_owner_mode(1'((p / 4) ^ (p % 2)));
			case (p % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 79;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 79;
				end
				default: begin
					gap_pct = 33;
					stall_pct = 33;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				c = random_cmd();
				if (c.command == CMD_INSERT)
					recent_scores[item_index % 4] = c.score;
				push_cmd(c);
				item_index++;
			end
		end

		// Drain, then idle long enough for any stray response beat to show.
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
